@@ sv/fsl_pkg.sv @@
package fsl_pkg;

  localparam int KindWidth   = 2;
  localparam int HopsWidth   = 8;
  localparam int SlotsWidth  = 10;
  localparam int ValueWidth  = 32;
  localparam int StatusWidth = 2;
  localparam int HeaderWords = 2;

  localparam logic [KindWidth-1:0] KIND_CALL  = 2'd0;
  localparam logic [KindWidth-1:0] KIND_RET   = 2'd1;
  localparam logic [KindWidth-1:0] KIND_STORE = 2'd2;
  localparam logic [KindWidth-1:0] KIND_LOAD  = 2'd3;

  localparam logic [StatusWidth-1:0] ST_OK       = 2'd0;
  localparam logic [StatusWidth-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [StatusWidth-1:0] ST_BASE     = 2'd2;
  localparam logic [StatusWidth-1:0] ST_RANGE    = 2'd3;

  typedef struct packed {
    logic                   load_item;
    logic                   clr_wr;
    logic                   hop_rd;
    logic                   hop_take;
    logic                   zero_wr;
    logic                   dyn_wr;
    logic                   stat_wr;
    logic                   ret_rd;
    logic                   ret_take;
    logic                   acc_wr;
    logic                   acc_rd;
    logic                   ld_take;
    logic                   set_st;
    logic [StatusWidth-1:0] status;
    logic                   finish;
  } fsl_cmd_t;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic                 clr_last;
    logic                 hops_zero;
    logic                 a_valid;
    logic                 overflow;
    logic                 top_zero;
    logic                 ret_range;
    logic                 acc_bad;
    logic                 zero_done;
    logic                 out_free;
  } fsl_stat_t;

endpackage

@@ sv/fsl_ram.sv @@
module fsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/fsl_datapath.sv @@
module fsl_datapath import fsl_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int WORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fsl_cmd_t               cmd_i,
  output fsl_stat_t              stat_o,
  input  logic [KindWidth-1:0]   kind_i,
  input  logic [HopsWidth-1:0]   level_hops_i,
  input  logic [SlotsWidth-1:0]  frame_slots_i,
  input  logic [SlotsWidth-1:0]  slot_index_i,
  input  logic [ValueWidth-1:0]  write_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ValueWidth-1:0]  read_value_o,
  output logic [StatusWidth-1:0] status_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int XW = WORD_WIDTH + 12;
  localparam logic [XW-1:0] DepthX = XW'(DEPTH);
  localparam logic [XW-1:0] LastX  = XW'(DEPTH - 1);
  localparam logic [XW-1:0] HdrX   = XW'(HeaderWords);

  logic [KindWidth-1:0]   kind_q;
  logic [HopsWidth-1:0]   hops_q;
  logic [SlotsWidth-1:0]  slots_q;
  logic [SlotsWidth-1:0]  index_q;
  logic [ValueWidth-1:0]  wval_q;
  logic [WORD_WIDTH-1:0]  a_q;
  logic [WORD_WIDTH-1:0]  top_q;
  logic [SlotsWidth-1:0]  cnt_q;
  logic [AW-1:0]          clr_q;
  logic                   rd_top_q;
  logic [StatusWidth-1:0] st_q;
  logic [ValueWidth-1:0]  rdv_q;
  logic                   out_valid_q;
  logic [ValueWidth-1:0]  out_rd_q;
  logic [StatusWidth-1:0] out_st_q;

  logic [XW-1:0]          a_x;
  logic [XW-1:0]          top_x;
  logic [XW-1:0]          ntop_x;
  logic [XW-1:0]          off_x;
  logic [XW-1:0]          fin_x;
  logic [XW-1:0]          zaddr_x;
  logic [WORD_WIDTH-1:0]  ram_rdata;
  logic [WORD_WIDTH-1:0]  rdata_eff;
  logic [WORD_WIDTH-1:0]  wword;
  logic [63:0]            ld_ext;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_WIDTH-1:0]  ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic                   raddr_zero;

  assign a_x     = XW'(a_q);
  assign top_x   = XW'(top_q);
  assign ntop_x  = top_x + XW'(slots_q) + HdrX;
  assign off_x   = XW'(index_q) + HdrX;
  assign fin_x   = a_x - off_x;
  assign zaddr_x = top_x + XW'(cnt_q) + XW'(1);

  assign wword     = WORD_WIDTH'(64'($signed(wval_q)));
  assign rdata_eff = rd_top_q ? top_q : ram_rdata;
  assign ld_ext    = 64'($signed(rdata_eff));

  assign stat_o.kind      = kind_q;
  assign stat_o.clr_last  = (clr_q == AW'(DEPTH - 1));
  assign stat_o.hops_zero = (hops_q == '0);
  assign stat_o.a_valid   = (a_x <= top_x) && (a_x < DepthX);
  assign stat_o.overflow  = (ntop_x > LastX);
  assign stat_o.top_zero  = (top_q == '0);
  assign stat_o.ret_range = (top_x > DepthX);
  assign stat_o.acc_bad   = (a_x < off_x) || (fin_x > top_x) || (fin_x >= DepthX);
  assign stat_o.zero_done = (cnt_q == slots_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = clr_q;
    ram_wdata = '0;
    if (cmd_i.zero_wr) begin
      ram_waddr = AW'(zaddr_x);
    end else if (cmd_i.dyn_wr) begin
      ram_waddr = AW'(ntop_x - XW'(1));
      ram_wdata = top_q;
    end else if (cmd_i.stat_wr) begin
      ram_waddr = AW'(ntop_x);
      ram_wdata = a_q;
    end else if (cmd_i.acc_wr) begin
      ram_waddr = AW'(fin_x);
      ram_wdata = wword;
    end else if (!cmd_i.clr_wr) begin
      ram_we = 1'b0;
    end
  end

  always_comb begin
    ram_re     = cmd_i.hop_rd || cmd_i.ret_rd || cmd_i.acc_rd;
    ram_raddr  = AW'(a_q);
    raddr_zero = (a_q == '0);
    if (cmd_i.ret_rd) begin
      ram_raddr  = AW'(top_x - XW'(1));
      raddr_zero = (top_x == XW'(1));
    end else if (cmd_i.acc_rd) begin
      ram_raddr  = AW'(fin_x);
      raddr_zero = (fin_x == '0);
    end
  end

  fsl_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.stat_wr) begin
        top_q <= WORD_WIDTH'(ntop_x);
      end else if (cmd_i.ret_take) begin
        top_q <= rdata_eff;
      end else if (cmd_i.acc_wr && fin_x == '0) begin
        top_q <= wword;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q  <= kind_i;
      hops_q  <= level_hops_i;
      slots_q <= frame_slots_i;
      index_q <= slot_index_i;
      wval_q  <= write_value_i;
      a_q     <= top_q;
      cnt_q   <= '0;
      st_q    <= ST_OK;
      rdv_q   <= '0;
    end
    if (cmd_i.hop_take) begin
      a_q    <= rdata_eff;
      hops_q <= hops_q - HopsWidth'(1);
    end
    if (cmd_i.zero_wr) begin
      cnt_q <= cnt_q + SlotsWidth'(1);
    end
    if (ram_re) begin
      rd_top_q <= raddr_zero;
    end
    if (cmd_i.set_st) begin
      st_q <= cmd_i.status;
    end
    if (cmd_i.ld_take) begin
      rdv_q <= ld_ext[ValueWidth-1:0];
    end
    if (cmd_i.finish) begin
      out_rd_q <= rdv_q;
      out_st_q <= st_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rd_q;
  assign status_o     = out_st_q;

  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.clr_wr, cmd_i.zero_wr, cmd_i.dyn_wr, cmd_i.stat_wr, cmd_i.acc_wr}))
    else $error("Two memory writes requested in one cycle.");

  a_top_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.stat_wr || cmd_i.ret_take || cmd_i.acc_wr) |=> $stable(top_q))
    else $error("Top address changed without a write command.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("Result register overwritten before it was taken.");

endmodule

@@ sv/fsl_ctrl.sv @@
module fsl_ctrl import fsl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fsl_stat_t stat_i,
  output fsl_cmd_t  cmd_o
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_DECODE    = 4'd2;
  localparam logic [3:0] S_HOP       = 4'd3;
  localparam logic [3:0] S_HOP_WAIT  = 4'd4;
  localparam logic [3:0] S_ZERO      = 4'd5;
  localparam logic [3:0] S_DYN       = 4'd6;
  localparam logic [3:0] S_STAT      = 4'd7;
  localparam logic [3:0] S_ACCESS    = 4'd8;
  localparam logic [3:0] S_LOAD_WAIT = 4'd9;
  localparam logic [3:0] S_RET_WAIT  = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.kind == KIND_CALL) begin
          if (stat_i.overflow) begin
            cmd_o.set_st = 1'b1;
            cmd_o.status = ST_OVERFLOW;
            state_d      = S_DONE;
          end else begin
            state_d = S_HOP;
          end
        end else if (stat_i.kind == KIND_RET) begin
          if (stat_i.top_zero) begin
            cmd_o.set_st = 1'b1;
            cmd_o.status = ST_BASE;
            state_d      = S_DONE;
          end else if (stat_i.ret_range) begin
            cmd_o.set_st = 1'b1;
            cmd_o.status = ST_RANGE;
            state_d      = S_DONE;
          end else begin
            cmd_o.ret_rd = 1'b1;
            state_d      = S_RET_WAIT;
          end
        end else begin
          state_d = S_HOP;
        end
      end
      S_HOP: begin
        if (stat_i.hops_zero) begin
          state_d = (stat_i.kind == KIND_CALL) ? S_ZERO : S_ACCESS;
        end else if (!stat_i.a_valid) begin
          cmd_o.set_st = 1'b1;
          cmd_o.status = ST_RANGE;
          state_d      = S_DONE;
        end else begin
          cmd_o.hop_rd = 1'b1;
          state_d      = S_HOP_WAIT;
        end
      end
      S_HOP_WAIT: begin
        cmd_o.hop_take = 1'b1;
        state_d        = S_HOP;
      end
      S_ZERO: begin
        if (stat_i.zero_done) begin
          state_d = S_DYN;
        end else begin
          cmd_o.zero_wr = 1'b1;
        end
      end
      S_DYN: begin
        cmd_o.dyn_wr = 1'b1;
        state_d      = S_STAT;
      end
      S_STAT: begin
        cmd_o.stat_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_ACCESS: begin
        if (stat_i.acc_bad) begin
          cmd_o.set_st = 1'b1;
          cmd_o.status = ST_RANGE;
          state_d      = S_DONE;
        end else if (stat_i.kind == KIND_STORE) begin
          cmd_o.acc_wr = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.acc_rd = 1'b1;
          state_d      = S_LOAD_WAIT;
        end
      end
      S_LOAD_WAIT: begin
        cmd_o.ld_take = 1'b1;
        state_d       = S_DONE;
      end
      S_RET_WAIT: begin
        cmd_o.ret_take = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_take_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.hop_take |-> $past(cmd_o.hop_rd))
    else $error("Link taken without a preceding memory read.");

  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_take |-> $past(cmd_o.acc_rd))
    else $error("Load data taken without a preceding memory read.");

endmodule

@@ sv/frame_stack_with_static_links_top.sv @@
// Activation-record stack for a block-structured interpreter, kept in one word memory
// whose entry 0 is the top-of-stack address. Each input beat is a call, return, store or
// load and produces exactly one output beat carrying the loaded word and a status code.
// After reset the block clears the whole memory, one word per cycle, before it accepts the
// first beat. Each static-link hop makes a registered memory read, and a call zeroes each
// variable slot of the new frame and then writes the two-word frame header. All of this
// passes through the single memory port pair, and the block takes no new beat until it
// has finished the last one.
module frame_stack_with_static_links_top import fsl_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // kind[1:0], level_hops[9:2], frame_slots[19:10], slot_index[29:20],
  // write_value[61:30], zero fill[63:62].
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_value[31:0], status[33:32], zero fill[39:34].
  output logic [39:0] m_axis_tdata_o
);

  fsl_cmd_t               cmd;
  fsl_stat_t              stat;
  logic [ValueWidth-1:0]  read_value;
  logic [StatusWidth-1:0] status;

  fsl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  fsl_datapath #(
    .DEPTH     (DEPTH),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (s_axis_tdata_i[1:0]),
    .level_hops_i (s_axis_tdata_i[9:2]),
    .frame_slots_i(s_axis_tdata_i[19:10]),
    .slot_index_i (s_axis_tdata_i[29:20]),
    .write_value_i(s_axis_tdata_i[61:30]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .read_value_o (read_value),
    .status_o     (status)
  );

  assign m_axis_tdata_o = {6'd0, status, read_value};

endmodule

@@ tb/sv/frame_stack_with_static_links_top_tb.sv @@
module frame_stack_with_static_links_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsl_pkg::*;

  localparam int Depth = 1024;
  localparam int IdleLimit = 10000;

  typedef struct packed {
    logic [KindWidth-1:0]  kind;
    logic [HopsWidth-1:0]  hops;
    logic [SlotsWidth-1:0] slots;
    logic [SlotsWidth-1:0] index;
    logic [ValueWidth-1:0] wval;
  } stack_op_t;

  typedef struct packed {
    logic [ValueWidth-1:0]  read_value;
    logic [StatusWidth-1:0] status;
  } stack_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [63:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;

  logic [ValueWidth-1:0] frame_mem [Depth];
  stack_res_t            expected_q [$];
  int                    errors = 0;
  int                    idle_cycles = 0;
  int                    stall_left = 0;
  bit                    no_gaps = 1'b0;

  frame_stack_with_static_links_top #(
    .DEPTH     (Depth),
    .WORD_WIDTH(ValueWidth)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Follows static links from the top; fails if a link is read from an address above the top or past the store.
  function automatic bit walk_links(input int unsigned hops, output longint unsigned where);
    longint unsigned top;
    longint unsigned a;
    top = 64'(frame_mem[0]);
    a = top;
    for (int i = 0; i < hops; i++) begin
      if (!(a <= top && a < Depth)) return 0;
      a = 64'(frame_mem[a]);
    end
    where = a;
    return 1;
  endfunction

  function automatic bit access_target(input stack_op_t op, output int unsigned target);
    longint unsigned top;
    longint unsigned a;
    longint unsigned off;
    top = 64'(frame_mem[0]);
    off = 64'(HeaderWords) + 64'(op.index);
    if (!walk_links(op.hops, a)) return 0;
    if (a < off || a - off > top || a - off >= Depth) return 0;
    target = 32'(a - off);
    return 1;
  endfunction

  function automatic stack_res_t apply_stack_op(input stack_op_t op);
    stack_res_t      res;
    longint unsigned top;
    longint unsigned ntop;
    longint unsigned a;
    int unsigned     target;
    top = 64'(frame_mem[0]);
    res.read_value = '0;
    res.status = ST_OK;
    case (op.kind)
      KIND_CALL: begin
        ntop = top + 64'(op.slots) + 64'(HeaderWords);
        if (ntop > Depth - 1) begin
          res.status = ST_OVERFLOW;
        end else if (!walk_links(op.hops, a)) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = 1; i <= op.slots; i++) frame_mem[top + i] = '0;
          frame_mem[ntop - 1] = top[ValueWidth-1:0];
          frame_mem[ntop] = a[ValueWidth-1:0];
          frame_mem[0] = ntop[ValueWidth-1:0];
        end
      end
      KIND_RET: begin
        if (top == 0) begin
          res.status = ST_BASE;
        end else if (top - 1 >= Depth) begin
          res.status = ST_RANGE;
        end else begin
          frame_mem[0] = frame_mem[top - 1];
        end
      end
      default: begin
        if (!access_target(op, target)) begin
          res.status = ST_RANGE;
        end else if (op.kind == KIND_STORE) begin
          frame_mem[target] = op.wval;
        end else begin
          res.read_value = frame_mem[target];
        end
      end
    endcase
    return res;
  endfunction

  function automatic stack_op_t make_op(input logic [KindWidth-1:0] kind,
                                        input int unsigned hops, input int unsigned slots,
                                        input int unsigned index,
                                        input logic [ValueWidth-1:0] wval);
    stack_op_t op;
    op.kind = kind;
    op.hops = HopsWidth'(hops);
    op.slots = SlotsWidth'(slots);
    op.index = SlotsWidth'(index);
    op.wval = wval;
    return op;
  endfunction

  function automatic stack_op_t random_op(input int noise_pct);
    stack_op_t       op;
    longint unsigned top;
    longint unsigned a;
    longint unsigned lower;
    int unsigned     nvars;
    int unsigned     pick;
    int unsigned     target;
    top = 64'(frame_mem[0]);
    op = make_op(KIND_LOAD, 0, 0, 0, $urandom);
    if ($urandom_range(99) < noise_pct) begin
      op.kind = KindWidth'($urandom_range(3));
      op.hops = HopsWidth'(($urandom_range(9) == 0) ? $urandom_range(255) :
                                                      $urandom_range(4));
      op.slots = SlotsWidth'(($urandom_range(3) == 0) ? $urandom_range(1021) :
                                                        $urandom_range(20));
      op.index = SlotsWidth'(($urandom_range(3) == 0) ? $urandom_range(1021) :
                                                        $urandom_range(20));
    end else begin
      pick = $urandom_range(99);
      if (top != 0 && (pick < 15 || (top > 700 && pick < 50))) begin
        op.kind = KIND_RET;
      end else if (pick < 35 || top == 0) begin
        op.kind = KIND_CALL;
        op.slots = SlotsWidth'(($urandom_range(9) == 0) ? $urandom_range(60) :
                                                          $urandom_range(6));
        op.hops = HopsWidth'($urandom_range(3));
      end else begin
        op.kind = (pick < 65) ? KIND_STORE : KIND_LOAD;
        op.hops = HopsWidth'($urandom_range(3));
        nvars = 0;
        if (walk_links(op.hops, a) && a >= 2 && a < Depth) begin
          lower = 64'(frame_mem[a - 1]);
          if (lower + 2 <= a) nvars = 32'(a - 2 - lower);
        end
        op.index = SlotsWidth'((nvars == 0) ? $urandom_range(3) : $urandom_range(nvars - 1));
        if ($urandom_range(9) == 0) op.index = SlotsWidth'(nvars);
      end
    end
    // Keep the top inside the store so that later beats still reach real frames.
    if (op.kind == KIND_RET && top != 0 && top <= Depth && frame_mem[top - 1] >= Depth) begin
      op.kind = KIND_LOAD;
    end
    if (op.kind == KIND_STORE && access_target(op, target) && target == 0) begin
      op.wval = op.wval % Depth;
    end
    return op;
  endfunction

  task automatic send_op(input stack_op_t op);
    int gap;
    @(negedge clk);
    s_valid <= 1'b1;
    s_data <= {2'b00, op.wval, op.index, op.slots, op.hops, op.kind};
    do @(posedge clk); while (!s_ready);
    expected_q.insert(expected_q.size(), apply_stack_op(op));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    s_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_base_errors();
    send_op(make_op(KIND_RET, 0, 0, 0, 0));
    send_op(make_op(KIND_LOAD, 0, 0, 0, 0));
    send_op(make_op(KIND_STORE, 255, 0, 1021, 0));
  endtask

  task automatic test_nested_frames();
    send_op(make_op(KIND_CALL, 0, 0, 0, 0));
    send_op(make_op(KIND_CALL, 0, 3, 0, 0));
    send_op(make_op(KIND_STORE, 0, 0, 0, 32'h7FFF_FFFF));
    send_op(make_op(KIND_STORE, 0, 0, 2, 32'h8000_0000));
    send_op(make_op(KIND_LOAD, 0, 0, 0, 0));
    send_op(make_op(KIND_LOAD, 0, 0, 2, 0));
    send_op(make_op(KIND_LOAD, 0, 0, 1, 0));
    send_op(make_op(KIND_LOAD, 0, 0, 5, 0));
    send_op(make_op(KIND_CALL, 1, 2, 0, 0));
    send_op(make_op(KIND_LOAD, 1, 0, 0, 0));
    send_op(make_op(KIND_LOAD, 255, 0, 0, 0));
    repeat (3) send_op(make_op(KIND_RET, 0, 0, 0, 0));
  endtask

  task automatic test_full_stack();
    send_op(make_op(KIND_CALL, 0, 1021, 0, 0));
    send_op(make_op(KIND_CALL, 0, 0, 0, 0));
    send_op(make_op(KIND_LOAD, 0, 0, 1021, 0));
    send_op(make_op(KIND_STORE, 0, 0, 1020, 32'hFFFF_FFFF));
    send_op(make_op(KIND_LOAD, 0, 0, 1020, 0));
    send_op(make_op(KIND_RET, 0, 0, 0, 0));
  endtask

  // A static link bent past the top must stop both calls and accesses that walk through it.
  task automatic test_bad_links();
    send_op(make_op(KIND_CALL, 0, 1, 0, 0));
    send_op(make_op(KIND_CALL, 0, 1, 0, 0));
    send_op(make_op(KIND_STORE, 0, 0, 1, 500));
    send_op(make_op(KIND_CALL, 3, 0, 0, 0));
    send_op(make_op(KIND_LOAD, 2, 0, 0, 0));
    repeat (2) send_op(make_op(KIND_RET, 0, 0, 0, 0));
  endtask

  task automatic test_random_programs(input int count, input int noise_pct);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(3) == 0);
      send_op(random_op(noise_pct));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_corrupt_top();
    if (frame_mem[0] < 2) send_op(make_op(KIND_CALL, 0, 0, 0, 0));
    send_op(make_op(KIND_STORE, 0, 0, frame_mem[0] - 2, Depth));
    send_op(make_op(KIND_LOAD, 0, 0, 0, 0));
    send_op(make_op(KIND_RET, 0, 0, 0, 0));
    if (frame_mem[0] < 2) send_op(make_op(KIND_CALL, 0, 0, 0, 0));
    if (frame_mem[0] < Depth) begin
      send_op(make_op(KIND_STORE, 0, 0, frame_mem[0] - 2, 32'hFFFF_FFFF));
    end
    repeat (2) begin
      send_op(make_op(KIND_RET, 0, 0, 0, 0));
      send_op(make_op(KIND_CALL, 0, 0, 0, 0));
      send_op(make_op(KIND_LOAD, 1, 0, 0, 0));
      send_op(make_op(KIND_LOAD, 0, 0, 1021, 0));
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      stall_left = pick_gap();
      m_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  always @(posedge clk) begin : check_results
    stack_res_t want;
    if (rst_n && m_valid && m_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, m_data);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_data[31:0] !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   m_data[31:0]);
          errors++;
        end
        if (m_data[33:32] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_data[33:32]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, IdleLimit);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Depth; i++) frame_mem[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_base_errors();
    test_nested_frames();
    test_full_stack();
    test_bad_links();
    test_random_programs(600, 10);
    wait_for_results();
    test_random_programs(500, 5);
    test_random_programs(200, 100);
    test_corrupt_top();
    wait_for_results();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/fsl_pkg.sv
sv/fsl_ram.sv
sv/fsl_datapath.sv
sv/fsl_ctrl.sv
sv/frame_stack_with_static_links_top.sv
tb/sv/frame_stack_with_static_links_top_tb.sv
